[rtl/icy_metadata_demux_macros.svh]
// Assertion macros for the ICY metadata demultiplexer checker.
// Uses the clk and rst names of the module that expands them.
`ifndef ICY_METADATA_DEMUX_MACROS_SVH
`define ICY_METADATA_DEMUX_MACROS_SVH

// Property checked outside of reset.
`define ICY_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that also covers the reset cycles.
`define ICY_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/icy_md_pkg.sv]
// Shared types and constants for the ICY metadata demultiplexer.
// No dependencies; imported by all RTL modules and the checker.
package icy_md_pkg;

  localparam int META_UNIT_BYTES = 16;
  localparam int BYTE_W          = 8;
  localparam int COUNT_W         = 24;
  // Wide enough for the largest block: 255 units.
  localparam int REM_W           = $clog2(255 * META_UNIT_BYTES + 1);

  typedef enum logic {
    KIND_AUDIO = 1'b0,
    KIND_META  = 1'b1
  } byte_kind_t;

  // One result request handed from the decoder to the output stage.
  typedef struct packed {
    logic               valid;
    byte_kind_t         kind;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } icy_res_t;

endpackage

[rtl/icy_metadata_demux.sv]
// Top level of the ICY (streaming radio) metadata demultiplexer.
// Instantiates icy_md_core and icy_md_outreg; uses icy_md_pkg.
//
// Usage:
//   The slave stream carries the raw station byte stream, one byte per
//   request, with a pause flag in s_tuser. Audio bytes are counted; after
//   meta_interval of them the next byte is a length byte L, and the following
//   L * 16 bytes are metadata. The master stream carries every audio byte
//   (unless paused, in which case it is dropped but still counted) and every
//   metadata byte; m_tuser tells them apart and m_tlast marks the final byte
//   of a metadata block. Length bytes produce no output request.
//   The user must write the interval register through cfg_wen/cfg_wdata only
//   while the stream is idle (not enforced); zero makes the whole stream audio.
// Timing:
//   m_tvalid rises for a result in the cycle after its byte is accepted. One
//   byte is taken every cycle while m_tready does not stall; the single output
//   register sets that figure, since it is reloaded in the same cycle it drains.
// Reset and stall:
//   rst is synchronous and returns the block to the audio phase with a zero
//   count and an empty output register; the interval reads zero. While the
//   downstream side holds m_tready low with a result pending, s_tready drops
//   and the pending result and all state hold.
module icy_metadata_demux
  import icy_md_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration: meta_interval.
  input  logic                cfg_wen,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  // Input stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
  input  logic                s_tuser,   // [0] pause_audio
  // Output stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
  output logic                m_tuser,   // [0] byte_kind (0 audio, 1 metadata)
  output logic                m_tlast    // meta_last
);

  logic [COUNT_W-1:0] meta_interval;
  logic               room;
  logic               take;
  icy_res_t           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_interval <= '0;
    end else if (cfg_wen) begin
      meta_interval <= cfg_wdata;
    end
  end

  // Nothing is accepted during reset, so no byte is lost to it.
  assign s_tready = !rst && room;
  assign take     = s_tvalid && s_tready;

  icy_md_core u_core (
    .clk           (clk),
    .rst           (rst),
    .meta_interval (meta_interval),
    .take          (take),
    .data_byte     (s_tdata),
    .pause_audio   (s_tuser),
    .res           (res)
  );

  icy_md_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res      (res),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[rtl/icy_md_core.sv]
// Stream state of the ICY demultiplexer: audio counter, metadata counter and
// per-byte decode. Depends on icy_md_pkg.
module icy_md_core
  import icy_md_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [COUNT_W-1:0]  meta_interval,
  input  logic                take,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                pause_audio,
  output icy_res_t            res
);

  logic               in_metadata;
  logic               in_metadata_next;
  logic [COUNT_W-1:0] audio_count;
  logic [COUNT_W-1:0] audio_count_next;
  logic [REM_W-1:0]   meta_remaining;
  logic [REM_W-1:0]   meta_remaining_next;
  logic [REM_W-1:0]   block_len;

  assign block_len = REM_W'(data_byte) * REM_W'(META_UNIT_BYTES);

  always_comb begin
    in_metadata_next    = in_metadata;
    audio_count_next    = audio_count;
    meta_remaining_next = meta_remaining;
    res.valid = 1'b0;
    res.kind  = KIND_AUDIO;
    res.data  = data_byte;
    res.last  = 1'b0;
    if (in_metadata && (meta_remaining != '0)) begin
      meta_remaining_next = meta_remaining - REM_W'(1);
      res.valid = 1'b1;
      res.kind  = KIND_META;
      res.last  = (meta_remaining == REM_W'(1));
      in_metadata_next = (meta_remaining != REM_W'(1));
    end else if ((meta_interval != '0) && (audio_count >= meta_interval)) begin
      // Length byte: loads the block size and emits nothing.
      meta_remaining_next = block_len;
      audio_count_next    = '0;
      in_metadata_next    = (block_len != '0);
    end else begin
      in_metadata_next = 1'b0;
      audio_count_next = audio_count + COUNT_W'(1);
      res.valid        = !pause_audio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_metadata    <= 1'b0;
      audio_count    <= '0;
      meta_remaining <= '0;
    end else if (take) begin
      in_metadata    <= in_metadata_next;
      audio_count    <= audio_count_next;
      meta_remaining <= meta_remaining_next;
    end
  end

endmodule

[rtl/icy_md_outreg.sv]
// Output register of the ICY demultiplexer: holds one result request until
// the downstream side takes it. Depends on icy_md_pkg.
module icy_md_outreg
  import icy_md_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  icy_res_t           res,
  output logic               room,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [BYTE_W-1:0]  m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);

  logic               full;
  logic [BYTE_W-1:0]  data;
  byte_kind_t         kind;
  logic               last;

  // The register can take a new request when empty or being drained now.
  assign room = !full || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= res.valid;
    end else if (m_tready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      data <= res.data;
      kind <= res.kind;
      last <= res.last;
    end
  end

  assign m_tvalid = full;
  assign m_tdata  = data;
  assign m_tuser  = kind;
  assign m_tlast  = last;

endmodule

[rtl/icy_md_checker.sv]
// Port-level checker for icy_metadata_demux, bound to the top level.
// Depends on icy_md_pkg and icy_metadata_demux_macros.svh.
`include "icy_metadata_demux_macros.svh"

module icy_md_checker
  import icy_md_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [BYTE_W-1:0]   s_tdata,
  input logic                s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [BYTE_W-1:0]   m_tdata,
  input logic                m_tuser,
  input logic                m_tlast
);

  `ICY_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")
  `ICY_ASSERT(a_last_is_meta, m_tvalid && m_tlast |-> m_tuser == KIND_META,
    "end of block marked on an audio byte")
  `ICY_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready,
    "input stalled with empty output register")
  `ICY_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
    "stalled output request changed")
  `ICY_ASSERT(a_hold_input,
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser),
    "stalled input request changed")

endmodule

bind icy_metadata_demux icy_md_checker u_checker (.*);

[sim/icy_metadata_demux_checker.sv]
// Checker for the ICY metadata demultiplexer: predicts and compares output bytes.
// Watches the config, input and output channels of the block; uses icy_md_pkg.
module icy_metadata_demux_checker
  import icy_md_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [BYTE_W-1:0]  s_tdata,
  input  logic               s_tuser,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [BYTE_W-1:0]  m_tdata,
  input  logic               m_tuser,
  input  logic               m_tlast,
  output int                 fail_count,
  output int                 pending,
  output int                 audio_out,
  output int                 meta_out,
  output int                 blocks_done,
  output int                 length_bytes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    byte_kind_t        kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } demux_byte_t;

  demux_byte_t        expected_bytes[$];
  logic [COUNT_W-1:0] interval;
  logic [COUNT_W-1:0] audio_since_len;
  logic [REM_W-1:0]   meta_left;
  logic               in_block;
  int                 outputs_seen;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Advances the predicted deframer state by one accepted stream byte.
  task automatic demux_byte(input logic [BYTE_W-1:0] b, input logic paused);
    demux_byte_t res;
    if (in_block && meta_left != 0) begin
      meta_left--;
      res.kind = KIND_META;
      res.data = b;
      res.last = (meta_left == 0);
      expected_bytes = {expected_bytes, res};
      if (meta_left == 0) in_block = 1'b0;
      return;
    end
    in_block = 1'b0;
    if (interval != 0 && audio_since_len >= interval) begin
      // Length byte: never forwarded, zero length goes straight back to audio.
      meta_left = REM_W'(int'(b) * META_UNIT_BYTES);
      audio_since_len = '0;
      in_block = (meta_left != 0);
      length_bytes++;
      return;
    end
    audio_since_len = audio_since_len + 1'b1;
    if (!paused) begin
      res.kind = KIND_AUDIO;
      res.data = b;
      res.last = 1'b0;
      expected_bytes = {expected_bytes, res};
    end
  endtask

  task automatic check_output();
    demux_byte_t want;
    outputs_seen++;
    if (expected_bytes.size() == 0) begin
      flag_error($sformatf("output %0d: byte %02h with nothing expected", outputs_seen, m_tdata));
      return;
    end
    want = expected_bytes.pop_front();
    if (byte_kind_t'(m_tuser) != want.kind)
      flag_error($sformatf("output %0d: kind %0d, expected %0d", outputs_seen, m_tuser,
                           want.kind));
    if (m_tdata != want.data)
      flag_error($sformatf("output %0d: byte %02h, expected %02h", outputs_seen, m_tdata,
                           want.data));
    if (m_tlast != want.last)
      flag_error($sformatf("output %0d: last %0d, expected %0d", outputs_seen, m_tlast,
                           want.last));
    if (m_tuser) meta_out++;
    else audio_out++;
    if (m_tlast) blocks_done++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      interval = '0;
      audio_since_len = '0;
      meta_left = '0;
      in_block = 1'b0;
      expected_bytes.delete();
    end else begin
      if (cfg_wen) interval = cfg_wdata;
      if (s_tvalid && s_tready) demux_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) check_output();
    end
    pending <= expected_bytes.size();
  end

endmodule

[sim/icy_metadata_demux_tb.sv]
// Top of the ICY metadata demultiplexer testbench: clock, reset, stimulus, verdict.
// Depends on icy_md_pkg, the icy_metadata_demux RTL and icy_metadata_demux_checker.
module icy_metadata_demux_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icy_md_pkg::*;

  // Random stream bytes after the directed part, and how many of them at the
  // end run without any idling on either side.
  localparam int RUN_ITEMS   = 2000;
  localparam int TAIL_ITEMS  = 200;
  // Cycles without any accepted request before the run is called hung. The
  // longest legal quiet stretch is a source gap plus a sink stall plus the
  // pause before a register write.
  localparam int STALL_LIMIT = 1000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [BYTE_W-1:0]  s_tdata = '0;    // [7:0] data_byte
  logic               s_tuser = 1'b0;  // [0] pause_audio
  logic               m_tvalid;
  logic               m_tready = 1'b1;
  logic [BYTE_W-1:0]  m_tdata;         // [7:0] out_byte
  logic               m_tuser;         // [0] byte_kind
  logic               m_tlast;         // meta_last

  int fail_count;
  int pending;
  int audio_out;
  int meta_out;
  int blocks_done;
  int length_bytes;

  // Stimulus bookkeeping. The stream position is tracked here only so that
  // length bytes can be given small values; checking never relies on it.
  bit                 no_idle = 1'b0;
  int unsigned        sent = 0;
  int unsigned        settings = 0;
  logic [COUNT_W-1:0] pos_interval = '0;
  logic [COUNT_W-1:0] pos_audio = '0;
  int                 pos_meta_left = 0;
  int unsigned        sink_hold = 0;
  int                 idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  icy_metadata_demux u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  icy_metadata_demux_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .audio_out    (audio_out),
    .meta_out     (meta_out),
    .blocks_done  (blocks_done),
    .length_bytes (length_bytes)
  );

  // Downstream back-pressure: m_tready drops for bursts of random length,
  // separated by ready stretches of random length. It stays high whenever
  // the stimulus asks for a stretch without idling.
  always @(posedge clk) begin
    if (no_idle) begin
      m_tready <= 1'b1;
      sink_hold = 0;
    end else if (sink_hold != 0) begin
      sink_hold--;
    end else if (!m_tready) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      sink_hold = $urandom_range(0, 8);
    end
  end

  // Watchdog: any accepted request on either stream resets the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no request accepted for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one stream byte, optionally after a random gap, and holds it until
  // the block takes it. tvalid is left high afterwards so that back-to-back
  // bytes run without a gap.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic paused);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= paused;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    // Follow the stream framing so that the next length byte can be chosen.
    if (pos_meta_left != 0) begin
      pos_meta_left--;
    end else if (pos_interval != 0 && pos_audio >= pos_interval) begin
      pos_meta_left = int'(b) * META_UNIT_BYTES;
      pos_audio = '0;
    end else begin
      pos_audio = pos_audio + 1'b1;
    end
  endtask

  // Stops the input, waits until every predicted result has left the block,
  // then writes the interval register.
  task automatic set_interval(input logic [COUNT_W-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    pos_interval = value;
    settings++;
  endtask

  initial begin
    int unsigned        target;
    int unsigned        roll;
    logic [COUNT_W-1:0] interval;
    logic [BYTE_W-1:0]  data_b;
    bit                 tail;

    tail = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Right after reset the interval is zero, so even the
    // extreme byte values and a paused byte are plain audio.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);

    // Interval 2 with three bytes already counted: the count is past the
    // interval, so the very next byte is a length byte, here zero.
    set_interval(24'd2);
    send_byte(8'h00, 1'b0);
    // Two audio bytes, one paused, then a one-unit metadata block with
    // pause toggling inside it, then audio again.
    send_byte(8'h5A, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    for (int i = 0; i < META_UNIT_BYTES; i++)
      send_byte(i[0] ? 8'hFF : 8'h00, i[1]);
    send_byte(8'h3C, 1'b0);

    // Largest interval, then lowered below the running count.
    set_interval(24'hFFFFFF);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'h33, 1'b0);
    set_interval(24'd1);
    send_byte(8'h00, 1'b1);

    // Random part: phases with a fresh interval each. Most intervals are
    // short so that many metadata blocks occur; length bytes are mostly
    // small so blocks finish, with a rare fully random length.
    target = sent + RUN_ITEMS;
    while (sent < target) begin
      roll = $urandom_range(0, 9);
      if (roll == 0)      interval = '0;
      else if (roll == 1) interval = 24'hFFFFFF;
      else if (roll == 2) interval = COUNT_W'($urandom());
      else                interval = COUNT_W'($urandom_range(1, 24));
      set_interval(interval);
      if (!tail) no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(30, 250)) begin
        if (sent + TAIL_ITEMS >= target) begin
          tail = 1'b1;
          no_idle = 1'b1;
        end
        if (pos_meta_left == 0 && pos_interval != 0 && pos_audio >= pos_interval) begin
          roll = $urandom_range(0, 39);
          if (roll == 0)     data_b = BYTE_W'($urandom_range(0, 255));
          else if (roll < 9) data_b = '0;
          else               data_b = BYTE_W'($urandom_range(1, 3));
        end else begin
          data_b = BYTE_W'($urandom_range(0, 255));
        end
        send_byte(data_b, $urandom_range(0, 3) == 0);
      end
    end

    // Drain: nothing more is offered; wait for the outstanding results, and
    // keep watching after that in case the block emits something unpredicted.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Run: %0d stream bytes under %0d interval settings, %0d length bytes.",
             sent, settings, length_bytes);
    $display("Out: %0d audio bytes, %0d metadata bytes in %0d closed blocks.",
             audio_out, meta_out, blocks_done);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/icy_md_pkg.sv
rtl/icy_md_core.sv
rtl/icy_md_outreg.sv
rtl/icy_metadata_demux.sv
rtl/icy_md_checker.sv
sim/icy_metadata_demux_checker.sv
sim/icy_metadata_demux_tb.sv
